// ===== hdl/tor_pkg.sv =====
// shared types and constants for the telnet option refuser
// telnet command codes, parse modes and the parser-to-emitter result struct
// no dependencies
package tor_pkg;

    // telnet command bytes
    localparam logic [7:0] IAC_BYTE = 8'hFF;
    localparam logic [7:0] CMD_WILL = 8'hFB;
    localparam logic [7:0] CMD_DONT = 8'hFE;
    localparam logic [7:0] CMD_DO   = 8'hFD;
    localparam logic [7:0] CMD_WONT = 8'hFC;
    localparam logic [7:0] CMD_SB   = 8'hFA;
    localparam logic [7:0] CMD_SE   = 8'hF0;

    // receive parser modes
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_IAC     = 3'd1,
        MODE_OPTION  = 3'd2,
        MODE_SKIP    = 3'd3,
        MODE_SKIPIAC = 3'd4
    } mode_t;

    // what one received byte turns into
    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_DATA  = 2'd1,
        RES_REPLY = 2'd2
    } res_kind_t;

    // reply words still to send after the leading IAC
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_OPT  = 2'd1,
        SEQ_CMD  = 2'd2
    } seq_t;

    typedef struct packed {
        res_kind_t  kind;
        logic [7:0] reply_cmd;   // DONT or WONT for a refusal
        logic [7:0] value;       // data byte or option byte
    } result_t;

endpackage

// ===== hdl/tor_rx_if.sv =====
// receive channel: one telnet byte per word
// valid/ready handshake, no dependencies
interface tor_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/tor_tx_if.sv =====
// transmit channel: host data byte or partner reply byte per word
// valid/ready handshake, no dependencies
interface tor_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       to_partner;
    logic       last;

    modport source (output valid, output out_byte, output to_partner, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input to_partner, input last,
                    output ready);
endinterface

// ===== hdl/telnet_option_refuser.sv =====
// telnet option refuser: data bytes pass to host, WILL/DO are refused
// an accepted byte's first output word appears in the output register in the next cycle
// throughput: one byte per cycle while the output is free; a refusal holds off input until its option word is loaded
// reset: asynchronous, parser returns to normal data mode, output empties
// depends on tor_pkg, tor_rx_if, tor_tx_if, tor_parser, tor_emitter
module telnet_option_refuser (
    input  logic     clk,
    input  logic     rst_n,
    tor_rx_if.sink   rx,
    tor_tx_if.source tx
);

    tor_pkg::result_t res;
    logic             can_take;
    logic             take;

    // input handshake
    assign rx.ready = can_take;
    assign take     = rx.valid && can_take;

    // byte classification and parse state
    tor_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx.rx_byte),
        .res     (res)
    );

    // output register and reply sequencing
    tor_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .res      (res),
        .can_take (can_take),
        .tx       (tx)
    );

endmodule

// ===== hdl/tor_parser.sv =====
// telnet receive parser: mode and held command registers plus byte classifier
// depends on tor_pkg
module tor_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    output tor_pkg::result_t    res
);

    tor_pkg::mode_t mode_reg;
    tor_pkg::mode_t mode_next;
    logic [7:0]     held_reg;
    logic [7:0]     held_next;

    // next mode and classification of the incoming byte
    always_comb
    begin
        mode_next     = mode_reg;
        held_next     = held_reg;
        res.kind      = tor_pkg::RES_NONE;
        res.reply_cmd = tor_pkg::CMD_DONT;
        res.value     = rx_byte;
        unique case (mode_reg)
            tor_pkg::MODE_IAC:
            begin
                held_next = rx_byte;
                mode_next = tor_pkg::MODE_OPTION;
            end
            tor_pkg::MODE_OPTION:
            begin
                if (held_reg == tor_pkg::CMD_WILL || held_reg == tor_pkg::CMD_DO)
                begin
                    res.kind      = tor_pkg::RES_REPLY;
                    res.reply_cmd = (held_reg == tor_pkg::CMD_WILL) ?
                                    tor_pkg::CMD_DONT : tor_pkg::CMD_WONT;
                    mode_next     = tor_pkg::MODE_NORMAL;
                end
                else if (held_reg == tor_pkg::CMD_SB)
                begin
                    mode_next = tor_pkg::MODE_SKIP;
                end
                else
                begin
                    mode_next = tor_pkg::MODE_NORMAL;
                end
            end
            tor_pkg::MODE_SKIP:
            begin
                if (rx_byte == tor_pkg::IAC_BYTE)
                begin
                    mode_next = tor_pkg::MODE_SKIPIAC;
                end
            end
            tor_pkg::MODE_SKIPIAC:
            begin
                mode_next = (rx_byte == tor_pkg::CMD_SE) ?
                            tor_pkg::MODE_NORMAL : tor_pkg::MODE_SKIP;
            end
            default:
            begin
                if (rx_byte == tor_pkg::IAC_BYTE)
                begin
                    mode_next = tor_pkg::MODE_IAC;
                end
                else
                begin
                    mode_next = tor_pkg::MODE_NORMAL;
                    res.kind  = tor_pkg::RES_DATA;
                end
            end
        endcase
    end

    // parser state, updated per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tor_pkg::MODE_NORMAL;
            held_reg <= 8'h00;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

    // a refusal only comes from the option byte
    a_reply_from_option: assert property (@(posedge clk) disable iff (!rst_n)
        res.kind == tor_pkg::RES_REPLY |-> mode_reg == tor_pkg::MODE_OPTION)
        else $error("reply produced outside option mode");

    // a command byte after IAC always leads to waiting for the option
    a_iac_to_option: assert property (@(posedge clk) disable iff (!rst_n)
        take && mode_reg == tor_pkg::MODE_IAC |=> mode_reg == tor_pkg::MODE_OPTION)
        else $error("command byte did not move parser to option mode");

endmodule

// ===== hdl/tor_emitter.sv =====
// output register and three-word reply sequencer
// depends on tor_pkg and tor_tx_if
module tor_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  tor_pkg::result_t    res,
    output logic                can_take,
    tor_tx_if.source            tx
);

    logic         out_valid_reg,  out_valid_next;
    logic [7:0]   out_byte_reg,   out_byte_next;
    logic         out_tp_reg,     out_tp_next;
    logic         out_last_reg,   out_last_next;
    tor_pkg::seq_t seq_reg,       seq_next;
    logic [7:0]   seq_cmd_reg,    seq_cmd_next;
    logic [7:0]   seq_opt_reg,    seq_opt_next;
    logic         slot_free;

    // output slot can be reloaded this cycle
    assign slot_free = !out_valid_reg || tx.ready;
    assign can_take  = (seq_reg == tor_pkg::SEQ_IDLE) && slot_free;

    // next contents of the output slot and reply sequencer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_tp_next    = out_tp_reg;
        out_last_next  = out_last_reg;
        seq_next       = seq_reg;
        seq_cmd_next   = seq_cmd_reg;
        seq_opt_next   = seq_opt_reg;
        if (out_valid_reg && tx.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (seq_reg != tor_pkg::SEQ_IDLE)
        begin
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                out_tp_next    = 1'b1;
                if (seq_reg == tor_pkg::SEQ_CMD)
                begin
                    out_byte_next = seq_cmd_reg;
                    out_last_next = 1'b0;
                    seq_next      = tor_pkg::SEQ_OPT;
                end
                else
                begin
                    out_byte_next = seq_opt_reg;
                    out_last_next = 1'b1;
                    seq_next      = tor_pkg::SEQ_IDLE;
                end
            end
        end
        else if (take)
        begin
            case (res.kind)
                tor_pkg::RES_DATA:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res.value;
                    out_tp_next    = 1'b0;
                    out_last_next  = 1'b1;
                end
                tor_pkg::RES_REPLY:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = tor_pkg::IAC_BYTE;
                    out_tp_next    = 1'b1;
                    out_last_next  = 1'b0;
                    seq_next       = tor_pkg::SEQ_CMD;
                    seq_cmd_next   = res.reply_cmd;
                    seq_opt_next   = res.value;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seq_reg       <= tor_pkg::SEQ_IDLE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            seq_reg       <= seq_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_tp_reg   <= out_tp_next;
        out_last_reg <= out_last_next;
        seq_cmd_reg  <= seq_cmd_next;
        seq_opt_reg  <= seq_opt_next;
    end

    assign tx.valid      = out_valid_reg;
    assign tx.out_byte   = out_byte_reg;
    assign tx.to_partner = out_tp_reg;
    assign tx.last       = out_last_reg;

    // with the command word pending, the slot holds the leading IAC
    a_seq_cmd_slot: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == tor_pkg::SEQ_CMD |->
            out_valid_reg && out_tp_reg && !out_last_reg && out_byte_reg == tor_pkg::IAC_BYTE)
        else $error("reply sequence lost its IAC word");

    // with only the option pending, the slot holds a non-final reply word
    a_seq_opt_slot: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == tor_pkg::SEQ_OPT |-> out_valid_reg && out_tp_reg && !out_last_reg)
        else $error("reply sequence lost its command word");

    // host data is always a single final word
    a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_tp_reg |-> out_last_reg)
        else $error("host data word without last");

endmodule
